// ----- hdl/tchfe_pkg.sv -----
// ----------------------------------------------------------------------------
// tchfe_pkg
// Shared types and constants for the ClientHello field extractor.
// ----------------------------------------------------------------------------
package tchfe_pkg;

    localparam int EXT_TABLE_DEPTH_DEF = 16;
    localparam int POSITION_BITS_DEF   = 25;

    localparam logic [7:0] HS_TYPE_CLIENT_HELLO = 8'h01;
    localparam int         HDR_BYTES            = 9;
    localparam logic [15:0] REC_HDR_LEN         = 16'd5;
    localparam logic [15:0] RANDOM_LEN          = 16'd32;
    localparam logic [15:0] EXT_TYPE_SNI        = 16'd0;
    localparam logic [15:0] EXT_TYPE_ALPN       = 16'd16;

    typedef enum logic [4:0] {
        PH_REC, PH_HS, PH_VER, PH_RAND, PH_SIDLEN, PH_SID, PH_CLEN, PH_CIPH,
        PH_COMPLEN, PH_COMP, PH_EXTSLEN, PH_EXTHDR, PH_SNIPFX, PH_SNITYPE,
        PH_SNILEN, PH_HOST, PH_ALPNLEN, PH_ALPNELEN, PH_ALPN, PH_EXTDATA,
        PH_TAIL, PH_STOP
    } phase_t;

    typedef enum logic [3:0] {
        FC_RECHDR, FC_HSHDR, FC_VERSION, FC_RANDOM, FC_SESSID, FC_CIPHER,
        FC_COMPR, FC_EXTHDR, FC_SNITYPE, FC_HOST, FC_ALPN, FC_EXTDATA,
        FC_LENGTH, FC_IGNORED
    } field_t;

    typedef enum logic [2:0] {
        ST_OK, ST_HELLO, ST_CIPHER, ST_SNI, ST_ALPN, ST_DUP, ST_LENGTH, ST_FULL
    } status_t;

    // one phase transition: either enter ph with len bytes, or fail with err
    typedef struct packed {
        phase_t      ph;
        logic [15:0] len;
        status_t     err;
    } step_t;

    typedef struct packed {
        logic wr;
        logic clr;
    } tbl_cmd_t;

    typedef struct packed {
        logic hit;
        logic full;
    } tbl_stat_t;

    typedef struct packed {
        field_t  code;
        logic    start;
        logic    fin;
        logic    done;
        status_t status;
    } res_t;

    function automatic field_t tag_of(input phase_t ph);
        field_t t;
        case (ph)
            PH_REC:      t = FC_RECHDR;
            PH_HS:       t = FC_HSHDR;
            PH_VER:      t = FC_VERSION;
            PH_RAND:     t = FC_RANDOM;
            PH_SID:      t = FC_SESSID;
            PH_CIPH:     t = FC_CIPHER;
            PH_COMP:     t = FC_COMPR;
            PH_EXTHDR:   t = FC_EXTHDR;
            PH_SNITYPE:  t = FC_SNITYPE;
            PH_HOST:     t = FC_HOST;
            PH_ALPN:     t = FC_ALPN;
            PH_EXTDATA:  t = FC_EXTDATA;
            PH_SIDLEN, PH_CLEN, PH_COMPLEN, PH_EXTSLEN, PH_SNIPFX, PH_SNILEN,
            PH_ALPNLEN, PH_ALPNELEN: t = FC_LENGTH;
            default:     t = FC_IGNORED;
        endcase
        return t;
    endfunction

    function automatic step_t go(input phase_t ph, input logic [15:0] len);
        step_t s;
        s.ph  = ph;
        s.len = len;
        s.err = ST_OK;
        return s;
    endfunction

    function automatic step_t stop(input status_t e);
        step_t s;
        s.ph  = PH_STOP;
        s.len = 16'd0;
        s.err = e;
        return s;
    endfunction

endpackage

// ----- hdl/tchfe_ext_table.sv -----
// ----------------------------------------------------------------------------
// tchfe_ext_table
// Seen extension types; the key is compared against all stored entries.
// ----------------------------------------------------------------------------
module tchfe_ext_table #(
    parameter int DEPTH = tchfe_pkg::EXT_TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          key,
    input  tchfe_pkg::tbl_cmd_t  cmd,
    output tchfe_pkg::tbl_stat_t stat
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [15:0]      tbl_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;

    always_comb begin
        stat.hit = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) < count_reg && tbl_reg[i] == key) begin
                stat.hit = 1'b1;
            end
        end
        stat.full = (count_reg >= CNT_W'(DEPTH));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clr) begin
            count_reg <= '0;
        end else if (cmd.wr) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr && !cmd.clr) begin
            tbl_reg[count_reg[IDX_W-1:0]] <= key;
        end
    end

endmodule

// ----- hdl/tchfe_parser.sv -----
// ----------------------------------------------------------------------------
// tchfe_parser
// Per-byte parse state and the tagging and status logic for one item.
// ----------------------------------------------------------------------------
module tchfe_parser #(
    parameter int EXT_TABLE_DEPTH = tchfe_pkg::EXT_TABLE_DEPTH_DEF,
    parameter int POSITION_BITS   = tchfe_pkg::POSITION_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output tchfe_pkg::res_t res
);
    localparam int PW = POSITION_BITS;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    logic [PW-1:0]        pos_reg, pos_next;
    tchfe_pkg::phase_t    phase_reg, phase_next;
    logic [15:0]          rem_reg, rem_next;
    logic [23:0]          acc_reg, acc_next;
    logic [23:0]          decl_reg, decl_next;
    logic [PW:0]          lend_reg, lend_next;
    logic [PW:0]          eend_reg, eend_next;
    logic [15:0]          pend_reg, pend_next;
    tchfe_pkg::status_t   err_reg, err_next;
    logic                 fresh_reg, fresh_next;

    logic [PW:0]          pos_ext;
    logic [23:0]          acc_sh;
    logic [15:0]          rem_dec;
    logic                 take, chain;
    tchfe_pkg::step_t     s1, s2;
    tchfe_pkg::tbl_cmd_t  cmd;
    tchfe_pkg::tbl_stat_t stat;
    tchfe_pkg::status_t   fin_status;

    function automatic tchfe_pkg::step_t bound_next(
        input logic [PW:0] p, input logic [PW:0] e,
        input tchfe_pkg::phase_t in_ph, input logic [15:0] in_len,
        input tchfe_pkg::phase_t out_ph, input logic [15:0] out_len,
        input tchfe_pkg::status_t code);
        tchfe_pkg::step_t s;
        if (p < e) begin
            s = tchfe_pkg::go(in_ph, in_len);
        end else if (p != e) begin
            s = tchfe_pkg::stop(code);
        end else begin
            s = tchfe_pkg::go(out_ph, out_len);
        end
        return s;
    endfunction

    tchfe_ext_table #(.DEPTH(EXT_TABLE_DEPTH)) u_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .key     (pend_next),
        .cmd     (cmd),
        .stat    (stat)
    );

    always_comb begin
        pos_next   = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
        pos_ext    = {1'b0, pos_next};
        acc_sh     = {acc_reg[15:0], data_byte};
        rem_dec    = (rem_reg != 16'd0) ? rem_reg - 16'd1 : 16'd0;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        decl_next  = decl_reg;
        lend_next  = lend_reg;
        eend_next  = eend_reg;
        pend_next  = pend_reg;
        err_next   = err_reg;
        fresh_next = fresh_reg;
        take       = 1'b0;
        chain      = 1'b0;
        s1         = tchfe_pkg::stop(tchfe_pkg::ST_OK);
        s2         = tchfe_pkg::stop(tchfe_pkg::ST_OK);
        cmd.wr     = 1'b0;
        res.code   = tchfe_pkg::FC_IGNORED;
        res.start  = 1'b0;
        res.fin    = 1'b0;

        if (phase_reg == tchfe_pkg::PH_TAIL) begin
            s1   = tchfe_pkg::stop(tchfe_pkg::ST_LENGTH);
            take = 1'b1;
        end else if (phase_reg != tchfe_pkg::PH_STOP) begin
            res.code   = tchfe_pkg::tag_of(phase_reg);
            res.start  = fresh_reg;
            fresh_next = 1'b0;
            if (phase_reg == tchfe_pkg::PH_HS && rem_reg == 16'd4 &&
                data_byte != tchfe_pkg::HS_TYPE_CLIENT_HELLO) begin
                s1   = tchfe_pkg::stop(tchfe_pkg::ST_HELLO);
                take = 1'b1;
            end else begin
                acc_next = acc_sh;
                rem_next = rem_dec;
                if (phase_reg == tchfe_pkg::PH_EXTHDR && rem_dec == 16'd2) begin
                    pend_next = acc_sh[15:0];
                end
                if (rem_dec == 16'd0) begin
                    res.fin = 1'b1;
                    take    = 1'b1;
                    case (phase_reg)
                        tchfe_pkg::PH_REC:    s1 = tchfe_pkg::go(tchfe_pkg::PH_HS, 16'd4);
                        tchfe_pkg::PH_HS: begin
                            decl_next = acc_sh;
                            s1 = tchfe_pkg::go(tchfe_pkg::PH_VER, 16'd2);
                        end
                        tchfe_pkg::PH_VER:
                            s1 = tchfe_pkg::go(tchfe_pkg::PH_RAND, tchfe_pkg::RANDOM_LEN);
                        tchfe_pkg::PH_RAND:   s1 = tchfe_pkg::go(tchfe_pkg::PH_SIDLEN, 16'd1);
                        tchfe_pkg::PH_SIDLEN:
                            s1 = tchfe_pkg::go(tchfe_pkg::PH_SID, {8'd0, acc_sh[7:0]});
                        tchfe_pkg::PH_SID:    s1 = tchfe_pkg::go(tchfe_pkg::PH_CLEN, 16'd2);
                        tchfe_pkg::PH_CLEN: begin
                            lend_next = pos_ext + (PW+1)'(acc_sh[15:0]);
                            s1 = bound_next(pos_ext, lend_next, tchfe_pkg::PH_CIPH, 16'd2,
                                tchfe_pkg::PH_COMPLEN, 16'd1, tchfe_pkg::ST_CIPHER);
                        end
                        tchfe_pkg::PH_CIPH:
                            s1 = bound_next(pos_ext, lend_reg, tchfe_pkg::PH_CIPH, 16'd2,
                                tchfe_pkg::PH_COMPLEN, 16'd1, tchfe_pkg::ST_CIPHER);
                        tchfe_pkg::PH_COMPLEN:
                            s1 = tchfe_pkg::go(tchfe_pkg::PH_COMP, {8'd0, acc_sh[7:0]});
                        tchfe_pkg::PH_COMP:   s1 = tchfe_pkg::go(tchfe_pkg::PH_EXTSLEN, 16'd2);
                        tchfe_pkg::PH_EXTSLEN: begin
                            if (acc_sh[15:0] != 16'd0) begin
                                s1 = tchfe_pkg::go(tchfe_pkg::PH_EXTHDR, 16'd4);
                            end else begin
                                // empty extension list: no new field opens
                                take       = 1'b0;
                                phase_next = tchfe_pkg::PH_TAIL;
                            end
                        end
                        tchfe_pkg::PH_EXTHDR: begin
                            if (pend_next == tchfe_pkg::EXT_TYPE_SNI) begin
                                eend_next = pos_ext + (PW+1)'(acc_sh[15:0]);
                                s1 = bound_next(pos_ext, eend_next, tchfe_pkg::PH_SNIPFX,
                                    16'd2, tchfe_pkg::PH_EXTHDR, 16'd4, tchfe_pkg::ST_SNI);
                            end else if (pend_next == tchfe_pkg::EXT_TYPE_ALPN) begin
                                s1 = tchfe_pkg::go(tchfe_pkg::PH_ALPNLEN, 16'd2);
                            end else if (stat.hit) begin
                                s1 = tchfe_pkg::stop(tchfe_pkg::ST_DUP);
                            end else if (stat.full) begin
                                s1 = tchfe_pkg::stop(tchfe_pkg::ST_FULL);
                            end else begin
                                cmd.wr = 1'b1;
                                s1 = tchfe_pkg::go(tchfe_pkg::PH_EXTDATA, acc_sh[15:0]);
                            end
                        end
                        tchfe_pkg::PH_SNIPFX:  s1 = tchfe_pkg::go(tchfe_pkg::PH_SNITYPE, 16'd1);
                        tchfe_pkg::PH_SNITYPE: s1 = tchfe_pkg::go(tchfe_pkg::PH_SNILEN, 16'd2);
                        tchfe_pkg::PH_SNILEN:
                            s1 = tchfe_pkg::go(tchfe_pkg::PH_HOST, acc_sh[15:0]);
                        tchfe_pkg::PH_HOST:
                            s1 = bound_next(pos_ext, eend_reg, tchfe_pkg::PH_SNIPFX, 16'd2,
                                tchfe_pkg::PH_EXTHDR, 16'd4, tchfe_pkg::ST_SNI);
                        tchfe_pkg::PH_ALPNLEN: begin
                            lend_next = pos_ext + (PW+1)'(acc_sh[15:0]);
                            s1 = bound_next(pos_ext, lend_next, tchfe_pkg::PH_ALPNELEN,
                                16'd1, tchfe_pkg::PH_EXTHDR, 16'd4, tchfe_pkg::ST_ALPN);
                        end
                        tchfe_pkg::PH_ALPNELEN:
                            s1 = tchfe_pkg::go(tchfe_pkg::PH_ALPN, {8'd0, acc_sh[7:0]});
                        tchfe_pkg::PH_ALPN:
                            s1 = bound_next(pos_ext, lend_reg, tchfe_pkg::PH_ALPNELEN, 16'd1,
                                tchfe_pkg::PH_EXTHDR, 16'd4, tchfe_pkg::ST_ALPN);
                        tchfe_pkg::PH_EXTDATA: s1 = tchfe_pkg::go(tchfe_pkg::PH_EXTHDR, 16'd4);
                        default:               s1 = tchfe_pkg::stop(tchfe_pkg::ST_OK);
                    endcase
                end
            end
        end

        // a zero-length body closes at once and opens the field after it
        if (take && s1.err == tchfe_pkg::ST_OK && s1.ph != tchfe_pkg::PH_STOP &&
            s1.len == 16'd0) begin
            chain = 1'b1;
            case (s1.ph)
                tchfe_pkg::PH_SID:     s2 = tchfe_pkg::go(tchfe_pkg::PH_CLEN, 16'd2);
                tchfe_pkg::PH_COMP:    s2 = tchfe_pkg::go(tchfe_pkg::PH_EXTSLEN, 16'd2);
                tchfe_pkg::PH_EXTDATA: s2 = tchfe_pkg::go(tchfe_pkg::PH_EXTHDR, 16'd4);
                tchfe_pkg::PH_HOST:
                    s2 = bound_next(pos_ext, eend_next, tchfe_pkg::PH_SNIPFX, 16'd2,
                        tchfe_pkg::PH_EXTHDR, 16'd4, tchfe_pkg::ST_SNI);
                tchfe_pkg::PH_ALPN:
                    s2 = bound_next(pos_ext, lend_next, tchfe_pkg::PH_ALPNELEN, 16'd1,
                        tchfe_pkg::PH_EXTHDR, 16'd4, tchfe_pkg::ST_ALPN);
                default: chain = 1'b0;
            endcase
        end
        if (chain) begin
            s1 = s2;
        end

        if (take) begin
            if (s1.err != tchfe_pkg::ST_OK || s1.ph == tchfe_pkg::PH_STOP) begin
                if (err_reg == tchfe_pkg::ST_OK) begin
                    err_next = s1.err;
                end
                phase_next = tchfe_pkg::PH_STOP;
            end else begin
                phase_next = s1.ph;
                rem_next   = s1.len;
                acc_next   = 24'd0;
                fresh_next = 1'b1;
            end
        end

        // final status, in priority order
        if (pos_next < PW'(tchfe_pkg::HDR_BYTES) || err_next == tchfe_pkg::ST_HELLO) begin
            fin_status = tchfe_pkg::ST_HELLO;
        end else if (pos_next == POS_MAX ||
                     32'(decl_next) != 32'(pos_next) - 32'(tchfe_pkg::HDR_BYTES)) begin
            fin_status = tchfe_pkg::ST_HELLO;
        end else if (err_next != tchfe_pkg::ST_OK) begin
            fin_status = err_next;
        end else if (phase_next == tchfe_pkg::PH_TAIL ||
                     (phase_next == tchfe_pkg::PH_EXTHDR && fresh_next)) begin
            fin_status = tchfe_pkg::ST_OK;
        end else begin
            fin_status = tchfe_pkg::ST_LENGTH;
        end

        res.done   = last_byte;
        res.status = last_byte ? fin_status : tchfe_pkg::ST_OK;
        cmd.clr    = step_en && last_byte;
        if (!step_en) begin
            cmd.wr = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && last_byte)) begin
            pos_reg   <= '0;
            phase_reg <= tchfe_pkg::PH_REC;
            rem_reg   <= tchfe_pkg::REC_HDR_LEN;
            acc_reg   <= '0;
            decl_reg  <= '0;
            lend_reg  <= '0;
            eend_reg  <= '0;
            pend_reg  <= '0;
            err_reg   <= tchfe_pkg::ST_OK;
            fresh_reg <= 1'b1;
        end else if (step_en) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            decl_reg  <= decl_next;
            lend_reg  <= lend_next;
            eend_reg  <= eend_next;
            pend_reg  <= pend_next;
            err_reg   <= err_next;
            fresh_reg <= fresh_next;
        end
    end

    a_stop_has_error: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == tchfe_pkg::PH_STOP |-> err_reg != tchfe_pkg::ST_OK)
        else $error("parser stopped without an error code");

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && last_byte |=> pos_reg == '0 && phase_reg == tchfe_pkg::PH_REC)
        else $error("parse state not cleared after the last byte");

    a_wr_only_new: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |-> !stat.hit && !stat.full)
        else $error("extension type stored while duplicate or table full");

endmodule

// ----- hdl/tls_client_hello_field_extractor.sv -----
// ----------------------------------------------------------------------------
// tls_client_hello_field_extractor
// Tags each byte of a ClientHello record and checks it on the last byte.
// ----------------------------------------------------------------------------
// Takes one record byte per cycle and gives one tagged item per byte in the
// next cycle, through an output register; a new byte is taken every cycle
// while the output is free or being taken. Each byte's tag, element marks and
// next parse state come from one pass of the parse logic, with the seen
// extension types compared against all stored table entries in parallel.
// The status is reported with the byte marked last, after which the parser
// is ready for a new record with no gap.
module tls_client_hello_field_extractor #(
    parameter int EXT_TABLE_DEPTH = tchfe_pkg::EXT_TABLE_DEPTH_DEF,
    parameter int POSITION_BITS   = tchfe_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // byte_value, element_start, element_end, status, pad
    output logic [3:0]  m_tuser,   // field_code
    output logic        m_tlast    // done_res
);
    logic            accept;
    tchfe_pkg::res_t res;
    logic            m_tvalid_reg;
    logic [15:0]     m_tdata_reg;
    logic [3:0]      m_tuser_reg;
    logic            m_tlast_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    tchfe_parser #(
        .EXT_TABLE_DEPTH (EXT_TABLE_DEPTH),
        .POSITION_BITS   (POSITION_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {3'd0, res.status, res.fin, res.start, s_tdata};
            m_tuser_reg <= res.code;
            m_tlast_reg <= res.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tlast_reg |-> m_tdata_reg[12:10] == tchfe_pkg::ST_OK)
        else $error("status given on a byte that is not the last");

    a_ignored_unmarked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg == tchfe_pkg::FC_IGNORED |->
        !m_tdata_reg[8] && !m_tdata_reg[9])
        else $error("ignored byte carries element marks");

    a_accept_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid_reg)
        else $error("accepted item not presented");

endmodule
